FILE: sv/dge_pkg.sv
// dge_pkg: shared constants, types and helpers of the dual gradient energy map
// used by dge_line_store, dge_root and dual_gradient_energy_map; no dependencies
`default_nettype none

package dge_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int ROW_SLOTS   = 3;
    localparam int PIX_W       = 24;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int DIM_W       = 11;
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int STORE_DEPTH = ROW_SLOTS * MAX_WIDTH;
    localparam int SUM_W       = 19;
    localparam int ROOT_W      = 27;
    localparam int ENERGY_W    = 14;
    localparam int ROOT_STEPS  = 14;

    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_HI  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_HI = DIM_W'(MAX_HEIGHT);

    // register index decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
            r = DIM_MIN;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // sum of squared r, g, b differences of two pixels
    function automatic logic [SUM_W-2:0] sq_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [7:0]       p;
        logic [7:0]       q;
        logic [7:0]       d;
        logic [SUM_W-2:0] s;
        s = '0;
        for (int k = 0; k < 3; k++)
        begin
            p = a[k*8 +: 8];
            q = b[k*8 +: 8];
            d = (p > q) ? (p - q) : (q - p);
            s = s + (SUM_W-1)'({8'd0, d} * {8'd0, d});
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dge_line_store.sv
// dge_line_store: three-row pixel line store, one write and one registered read port
// depends on dge_pkg
`default_nettype none

module dge_line_store
(
    input  wire logic                     clk,
    input  wire dge_pkg::store_req_t      req,
    input  wire logic [dge_pkg::PIX_W-1:0] wr_data,
    output logic      [dge_pkg::PIX_W-1:0] rd_data
);
    import dge_pkg::*;

    logic [PIX_W-1:0] mem [0:STORE_DEPTH-1];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/dge_root.sv
// dge_root: iterative integer square root, two radicand bits per cycle
// depends on dge_pkg
`default_nettype none

module dge_root
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [dge_pkg::ROOT_W-1:0]    radicand,
    output logic                               done,
    output logic      [dge_pkg::ENERGY_W-1:0]  root
);
    import dge_pkg::*;

    localparam logic [ROOT_W-1:0] BIT_TOP = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] res_reg, res_next;
    logic [ROOT_W-1:0] bit_reg, bit_next;
    logic [ROOT_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = BIT_TOP;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[ROOT_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == ROOT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ENERGY_W-1:0];

endmodule

`default_nettype wire

FILE: sv/dual_gradient_energy_map.sv
// dual_gradient_energy_map: streaming dual gradient energy of raster pixels
// depends on dge_pkg, dge_line_store and dge_root
`default_nettype none

//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------------
//  pixels   | s_tvalid s_tready s_tdata        | one argb pixel per request
//  energy   | m_tvalid m_tready m_tdata m_tlast | one energy result per request
//           | m_tuser                          |
//  config   | psel penable pwrite paddr ...    | frame_width at 0x0, frame_height 0x4
//
// a first-row pixel is only stored; any other pixel yields one to three results, each
// computed from four line store reads and a 14-step square root
// the output register lets the next pixel in while a result waits for m_tready
// reset and any register write restart the frame at row 0, column 0

module dual_gradient_energy_map
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pixel_argb
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // energy_q4, pixel_column, pixel_row, zero pad
    output logic             m_tlast,   // run_last
    output logic             m_tuser,   // frame_last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import dge_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_EMIT = 4'b1000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;
    logic              y_one_reg;
    logic [SLOT_W-1:0] cur_slot_reg, prev_slot_reg, prev2_slot_reg;
    logic [2:0]        jobs_reg, jobs_next;
    logic [2:0]        rd_cnt_reg, rd_cnt_next;
    logic [PIX_W-1:0]  opa_reg;
    logic [SUM_W-1:0]  acc_reg;

    logic              out_valid_reg;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_rl_reg, out_fl_reg;

    logic              cfg_wr, pix_acc, out_load;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              last_col, last_row;
    logic [SLOT_W-1:0] prev_slot, prev2_slot;

    logic [COL_W-1:0]  xc, xl, xr;
    logic [SLOT_W-1:0] mid_slot, up_slot, dn_slot;
    logic [ROW_W-1:0]  yout;
    logic              job_fl, job_rl;
    logic [2:0]        job_bit;

    store_req_t        store_req;
    logic [PIX_W-1:0]  rd_data;
    logic              root_start, root_done;
    logic [ENERGY_W-1:0] root_val;
    logic [SUM_W-1:0]  full_sum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_FRAME_HEIGHT) ? {21'd0, height_reg}
                                                    : {21'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_HI;
            height_reg <= HEIGHT_HI;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_FRAME_HEIGHT)
                height_reg <= pwdata[DIM_W-1:0];
            else
                width_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign w_eff    = clamp_dim(width_reg, WIDTH_HI);
    assign h_eff    = clamp_dim(height_reg, HEIGHT_HI);
    assign last_col = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;

    assign s_tready = (state_reg == ST_IDLE);
    assign pix_acc  = s_tvalid && s_tready;

    assign prev_slot  = (slot_reg == SLOT_W'(0)) ? SLOT_W'(2) : slot_reg - SLOT_W'(1);
    assign prev2_slot = (slot_reg == SLOT_W'(0)) ? SLOT_W'(1) :
                        (slot_reg == SLOT_W'(1)) ? SLOT_W'(2) : SLOT_W'(0);

    // frame position
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (cfg_wr)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end
        else if (pix_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    slot_next = (slot_reg == SLOT_W'(2)) ? SLOT_W'(0)
                                                         : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // pending result jobs of the current pixel, lowest first
    always_comb
    begin
        if (jobs_reg[0])
        begin
            job_bit  = 3'b001;
            xc       = x_reg;
            mid_slot = prev_slot_reg;
            up_slot  = y_one_reg ? prev_slot_reg : prev2_slot_reg;
            dn_slot  = cur_slot_reg;
            yout     = y_reg - ROW_W'(1);
            job_fl   = 1'b0;
            job_rl   = !(jobs_reg[1] || jobs_reg[2]);
        end
        else if (jobs_reg[1])
        begin
            job_bit  = 3'b010;
            xc       = x_reg - COL_W'(1);
            mid_slot = cur_slot_reg;
            up_slot  = prev_slot_reg;
            dn_slot  = cur_slot_reg;
            yout     = y_reg;
            job_fl   = 1'b0;
            job_rl   = !jobs_reg[2];
        end
        else
        begin
            job_bit  = 3'b100;
            xc       = x_reg;
            mid_slot = cur_slot_reg;
            up_slot  = prev_slot_reg;
            dn_slot  = cur_slot_reg;
            yout     = y_reg;
            job_fl   = 1'b1;
            job_rl   = 1'b1;
        end
        xl = (xc == '0) ? xc : xc - COL_W'(1);
        xr = (({1'b0, xc} + DIM_W'(1)) >= w_eff) ? xc : xc + COL_W'(1);
    end

    always_comb
    begin
        store_req.wr_en   = pix_acc;
        store_req.wr_addr = {slot_reg, col_reg};
        store_req.rd_en   = (state_reg == ST_READ) && (rd_cnt_reg <= 3'd3);
        case (rd_cnt_reg[1:0])
            2'd0:    store_req.rd_addr = {mid_slot, xl};
            2'd1:    store_req.rd_addr = {mid_slot, xr};
            2'd2:    store_req.rd_addr = {up_slot, xc};
            default: store_req.rd_addr = {dn_slot, xc};
        endcase
    end

    dge_line_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .wr_data (s_tdata[PIX_W-1:0]),
        .rd_data (rd_data)
    );

    assign full_sum   = acc_reg + {1'b0, sq_diff(opa_reg, rd_data)};
    assign root_start = (state_reg == ST_READ) && (rd_cnt_reg == 3'd4);

    dge_root u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({full_sum, 8'd0}),
        .done     (root_done),
        .root     (root_val)
    );

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        jobs_next   = jobs_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_cnt_next = '0;
                if (pix_acc)
                begin
                    jobs_next = {last_row && last_col,
                                 last_row && (col_reg != '0),
                                 1'b1};
                    if (row_reg != '0)
                        state_next = ST_READ;
                    else
                        jobs_next = '0;
                end
            end
            ST_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd4)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                rd_cnt_next = '0;
                if (out_load)
                begin
                    jobs_next  = jobs_reg & ~job_bit;
                    state_next = job_rl ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                jobs_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            jobs_reg      <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            jobs_reg   <= jobs_next;
            rd_cnt_reg <= rd_cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            x_reg          <= col_reg;
            y_reg          <= row_reg;
            y_one_reg      <= (row_reg == ROW_W'(1));
            cur_slot_reg   <= slot_reg;
            prev_slot_reg  <= prev_slot;
            prev2_slot_reg <= prev2_slot;
        end
        if (state_reg == ST_READ)
        begin
            case (rd_cnt_reg)
                3'd1:    opa_reg <= rd_data;
                3'd2:    acc_reg <= {1'b0, sq_diff(opa_reg, rd_data)};
                3'd3:    opa_reg <= rd_data;
                default: ;
            endcase
        end
        if (out_load)
        begin
            out_energy_reg <= root_val;
            out_col_reg    <= xc;
            out_row_reg    <= yout;
            out_rl_reg     <= job_rl;
            out_fl_reg     <= job_fl;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_row_reg, out_col_reg, out_energy_reg};
    assign m_tlast  = out_rl_reg;
    assign m_tuser  = out_fl_reg;

endmodule

`default_nettype wire
